// ----- hw/rtl/base64_stream_encoder_defines.svh -----
// Assertion macros for the base64 stream encoder checker.
// No dependencies; included by the checker file only.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Generic clocked property, disabled while reset is asserted
`define B64_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Condition that must hold whenever a qualifier is high
`define B64_ASSERT_WHEN(lbl, clk, rstn, qual, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (qual) |-> (cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/b64_pkg.sv -----
// Shared types, constants and the sextet-to-ASCII mapping for the base64 encoder.
// No dependencies; imported by all other files but the defines header.
`timescale 1ns / 1ps

package b64_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned CharW        = 7;
  localparam int unsigned SextetW      = 6;
  localparam int unsigned LeftW        = 4;
  localparam int unsigned MaxChars     = 4;
  localparam int unsigned SymIdxW      = 2;
  localparam int unsigned QueueDepthDef = 2;

  // ASCII codes
  localparam logic [CharW-1:0] CharUpperA = 7'h41;
  localparam logic [CharW-1:0] CharLowerA = 7'h61;
  localparam logic [CharW-1:0] CharDigit0 = 7'h30;
  localparam logic [CharW-1:0] CharPlus   = 7'h2B;
  localparam logic [CharW-1:0] CharSlash  = 7'h2F;
  localparam logic [CharW-1:0] CharMinus  = 7'h2D;
  localparam logic [CharW-1:0] CharUnder  = 7'h5F;
  localparam logic [CharW-1:0] CharPad    = 7'h3D;

  // Position within the current 3-byte group
  typedef enum logic [1:0] {
    PhaseZero = 2'd0,
    PhaseOne  = 2'd1,
    PhaseTwo  = 2'd2
  } phase_e;

  // One output symbol: a 6-bit code or a pad character
  typedef struct packed {
    logic               pad;
    logic [SextetW-1:0] code;
  } sym_t;

  // Work for the back end: the characters caused by one input byte
  typedef struct packed {
    sym_t [MaxChars-1:0] sym;
    logic [SymIdxW-1:0]  last_idx;
    logic                eot;
    logic                url;
  } job_t;

  // Queue head status seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // Map a 6-bit code to its ASCII character in the selected alphabet
  function automatic logic [CharW-1:0] sextet_char(input logic [SextetW-1:0] code,
                                                   input logic url);
    logic [CharW-1:0] c;
    if (code < 6'd26) begin
      c = CharUpperA + CharW'(code);
    end else if (code < 6'd52) begin
      c = CharLowerA + CharW'(code - 6'd26);
    end else if (code < 6'd62) begin
      c = CharDigit0 + CharW'(code - 6'd52);
    end else if (code == 6'd62) begin
      c = url ? CharMinus : CharPlus;
    end else begin
      c = url ? CharUnder : CharSlash;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/b64_ifs.sv -----
// Valid/ready channel interfaces: byte input, character output, mode register write.
// Depends on b64_pkg for field widths.
`timescale 1ns / 1ps

interface b64_in_if import b64_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             final_byte;
  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b64_out_if import b64_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             end_of_text;
  modport source (output valid, out_char, end_of_text, input ready);
  modport sink   (input valid, out_char, end_of_text, output ready);
endinterface

interface b64_cfg_if ();
  logic valid;
  logic ready;
  logic url_safe_mode;
  modport source (output valid, url_safe_mode, input ready);
  modport sink   (input valid, url_safe_mode, output ready);
endinterface

// ----- hw/rtl/b64_fifo.sv -----
// Short job queue between the encoder front end and the character back end.
// Depends on b64_pkg for job_t and head_t.
`timescale 1ns / 1ps

module b64_fifo import b64_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  job_i,
  output logic  full_o,
  input  logic  pop_i,
  output head_t head_o
);

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(QueueDepth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(QueueDepth);

  job_t             slots_q [QueueDepth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = slots_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && head_o.valid;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ----- hw/rtl/b64_front.sv -----
// Front end: takes bytes, tracks group phase and leftover bits, builds character jobs.
// Also holds the mode register. Depends on b64_pkg and the channel interfaces.
`timescale 1ns / 1ps

module b64_front import b64_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  b64_in_if.sink        in_i,
  b64_cfg_if.sink       cfg_i,
  input  logic          full_i,
  output logic          push_o,
  output job_t          job_o
);

  phase_e             phase_q, phase_d;
  logic [LeftW-1:0]   left_q, left_d;
  logic               url_q;

  logic [ByteW-1:0]   b;
  logic               fin;
  logic [SextetW-1:0] main0, main1, tail;
  logic               two_main;
  phase_e             after;
  logic [LeftW-1:0]   after_left;

  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i;
  assign cfg_i.ready = 1'b1;
  assign b           = in_i.data_byte;
  assign fin         = in_i.final_byte;

  // split the byte against the current phase
  always_comb begin
    main1    = b[5:0];
    unique case (phase_q)
      PhaseOne: begin
        main0      = {left_q[1:0], b[7:4]};
        two_main   = 1'b0;
        after      = PhaseTwo;
        after_left = b[3:0];
        tail       = {b[3:0], 2'b00};
      end
      PhaseTwo: begin
        main0      = {left_q, b[7:6]};
        two_main   = 1'b1;
        after      = PhaseZero;
        after_left = '0;
        tail       = '0;
      end
      default: begin
        main0      = b[7:2];
        two_main   = 1'b0;
        after      = PhaseOne;
        after_left = {2'b00, b[1:0]};
        tail       = {b[1:0], 4'b0000};
      end
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    if (push_o) begin
      phase_d = fin ? PhaseZero : after;
      left_d  = fin ? '0 : after_left;
    end
  end

  // job contents: byte characters; final byte adds flush, pads in standard mode
  always_comb begin
    job_o          = '0;
    job_o.eot      = fin;
    job_o.url      = url_q;
    job_o.sym[0]   = '{pad: 1'b0, code: main0};
    job_o.last_idx = 2'd0;
    if (two_main) begin
      job_o.sym[1]   = '{pad: 1'b0, code: main1};
      job_o.last_idx = 2'd1;
    end else if (fin) begin
      job_o.sym[1]   = '{pad: 1'b0, code: tail};
      job_o.sym[2]   = '{pad: 1'b1, code: '0};
      job_o.sym[3]   = '{pad: 1'b1, code: '0};
      if (url_q) begin
        job_o.last_idx = 2'd1;
      end else if (after == PhaseOne) begin
        job_o.last_idx = 2'd3;
      end else begin
        job_o.last_idx = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseZero;
      left_q  <= '0;
      url_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      if (cfg_i.valid) begin
        url_q <= cfg_i.url_safe_mode;
      end
    end
  end

endmodule

// ----- hw/rtl/b64_back.sv -----
// Back end: walks a queued job into the output register, one char per ready cycle.
// Depends on b64_pkg for head_t and sextet_char, and on the output interface.
`timescale 1ns / 1ps

module b64_back import b64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  head_t      head_i,
  output logic       pop_o,
  b64_out_if.source  out_o
);

  logic [SymIdxW-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   out_char_q;
  logic               out_eot_q;
  logic               load, last_sym;
  sym_t               sym;

  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = out_char_q;
  assign out_o.end_of_text = out_eot_q;

  // load a character when the output register is free or being drained
  always_comb begin
    load        = head_i.valid && (!out_valid_q || out_o.ready);
    last_sym    = (idx_q == head_i.job.last_idx);
    pop_o       = load && last_sym;
    sym         = head_i.job.sym[idx_q];
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last_sym ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= sym.pad ? CharPad : sextet_char(sym.code, head_i.job.url);
      out_eot_q  <= head_i.job.eot && last_sym;
    end
  end

endmodule

// ----- hw/rtl/base64_stream_encoder.sv -----
// Base64 stream encoder (RFC 4648) top level: front end, job queue, back end.
// Depends on b64_pkg, the channel interfaces, b64_front, b64_fifo and b64_back.
//
// Usage:
//   in_i   : one byte per transfer, final_byte set on the last byte of a stream.
//   out_o  : one ASCII character per transfer, end_of_text on the last character.
//   cfg_i  : writes url_safe_mode (0 standard with '=' padding, 1 URL-safe,
//            no padding); always ready. The user writes it only while no
//            character is pending; the block does not enforce this.
// Characters reach out_o through the job queue and the output register. A byte
//   yields one or two characters, a final byte up to four (flush plus padding).
// Throughput: the back end emits one character per cycle while out_o.ready is
//   high, so the block takes a byte per cycle in bursts, three bytes per four
//   characters sustained; the queue of QueueDepth jobs absorbs the difference.
// Reset clears phase, leftover bits, mode and the queue; no output is pending.
// When the receiver stalls, the character holds in the output register, the
//   queue fills and in_i.ready drops once it is full.
`timescale 1ns / 1ps

module base64_stream_encoder import b64_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64_in_if.sink     in_i,
  b64_cfg_if.sink    cfg_i,
  b64_out_if.source  out_o
);

  logic  push, full, pop;
  job_t  job;
  head_t head;

  b64_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  b64_fifo #(
    .QueueDepth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  b64_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ----- hw/rtl/b64_checker.sv -----
// Port-level checker for the base64 stream encoder, bound to the top level.
// Depends on b64_pkg and base64_stream_encoder_defines.svh.
`timescale 1ns / 1ps
`include "base64_stream_encoder_defines.svh"

module b64_checker import b64_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i,
  input logic             cfg_mode_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] out_char_i,
  input logic             out_eot_i
);

  logic mode_q;
  logic legal_char;

  // track the mode register from its write transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      mode_q <= cfg_mode_i;
    end
  end

  assign legal_char = (out_char_i >= CharUpperA && out_char_i <= 7'h5A) ||
                      (out_char_i >= CharLowerA && out_char_i <= 7'h7A) ||
                      (out_char_i >= CharDigit0 && out_char_i <= 7'h39) ||
                      out_char_i == CharPlus || out_char_i == CharSlash ||
                      out_char_i == CharMinus || out_char_i == CharUnder ||
                      out_char_i == CharPad;

  `B64_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_char_i) && $stable(out_eot_i)), "stalled character changed")
  `B64_ASSERT_WHEN(a_legal, clk_i, rst_ni, out_valid_i, legal_char, "character outside alphabet")
  `B64_ASSERT_WHEN(a_url_set, clk_i, rst_ni, out_valid_i && mode_q, out_char_i != CharPad && out_char_i != CharPlus && out_char_i != CharSlash, "standard character in URL-safe mode")
  `B64_ASSERT_WHEN(a_std_set, clk_i, rst_ni, out_valid_i && !mode_q, out_char_i != CharMinus && out_char_i != CharUnder, "URL-safe character in standard mode")

endmodule

bind base64_stream_encoder b64_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_mode_i  (cfg_i.url_safe_mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_eot_i   (out_o.end_of_text)
);
